// ===== hw/rtl/alus_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alus_pkg - shared types, codes and arithmetic for the linear upsampler
// Holds the command handed from the front end to the back end, the
// configuration register indexes and the interpolation point function.
// ----------------------------------------------------------------------------
package alus_pkg;

    // Configuration register indexes
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_RATE_CODE   = 1'b0;
    localparam t_cfg_index CFG_WIDE_OUTPUT = 1'b1;
    localparam int unsigned CFG_DATA_W     = 2;

    // Rate codes (anything above 2x means 4x)
    localparam logic [1:0] RATE_1X = 2'd0;
    localparam logic [1:0] RATE_2X = 2'd1;

    // Default depth of the command queue
    localparam int unsigned ALUS_QUEUE_DEPTH = 2;

    localparam logic [15:0] SIGN_FLIP  = 16'h8000;
    localparam logic [3:0]  BYTE_SHIFT = 4'd8;

    // One decoded item, ready for the back end
    typedef struct packed {
        logic [7:0] prev;      // held sample
        logic [7:0] cur;       // new sample
        logic [1:0] shift;     // log2 of the factor
        logic       wide;      // signed 16-bit output
        logic       has_prev;  // interpolated points are due
        logic       last;      // end of buffer: copies are due
    } t_cmd;

    // Back end phase
    typedef enum logic {
        PH_INTERP,
        PH_COPY
    } t_phase;

    // log2 of the upsampling factor
    function automatic logic [1:0] rate_to_shift(input logic [1:0] rate);
        logic [1:0] sh;
        case (rate)
            RATE_1X: sh = 2'd0;
            RATE_2X: sh = 2'd1;
            default: sh = 2'd2;
        endcase
        return sh;
    endfunction

    // Point k of factor 1<<shift between a and b, in output form
    function automatic logic [15:0] interp_point(input logic [7:0] a,
                                                 input logic [7:0] b,
                                                 input logic [1:0] k,
                                                 input logic [1:0] shift,
                                                 input logic       wide);
        logic [2:0]  f;
        logic [2:0]  fk;
        logic [9:0]  s;
        logic [15:0] u;
        logic [15:0] res;
        f   = 3'd1 << shift;
        fk  = f - {1'b0, k};
        s   = 10'(fk) * 10'(a) + 10'(k) * 10'(b);
        u   = {6'b0, s} << (BYTE_SHIFT - {2'b0, shift});
        if (wide) begin
            res = u ^ SIGN_FLIP;
        end else begin
            res = {8'b0, 8'(s >> shift)};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/alus_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alus_front - input acceptance and classification
// Takes input items, pairs each with the held sample and the configuration
// in force, and pushes one command per item into the queue.
// ----------------------------------------------------------------------------
module alus_front
    import alus_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_sample_in,
    input  wire logic       i_end_of_buffer,
    input  wire logic [1:0] i_rate_code,
    input  wire logic       i_wide_output,
    input  wire logic       i_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [7:0] r_prev_sample;
    logic       r_have_prev;
    logic       accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept;

    // Command for the back end
    always_comb begin
        o_cmd.prev     = r_prev_sample;
        o_cmd.cur      = i_sample_in;
        o_cmd.shift    = rate_to_shift(i_rate_code);
        o_cmd.wide     = i_wide_output;
        o_cmd.has_prev = r_have_prev;
        o_cmd.last     = i_end_of_buffer;
    end

    // Held sample: end of buffer drops it, otherwise the new one is kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample <= '0;
            r_have_prev   <= 1'b0;
        end else if (accept) begin
            if (i_end_of_buffer) begin
                r_have_prev <= 1'b0;
            end else begin
                r_prev_sample <= i_sample_in;
                r_have_prev   <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/alus_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alus_queue - short command queue between front and back end
// Circular buffer of commands with a fill count; head is read directly.
// ----------------------------------------------------------------------------
module alus_queue
    import alus_pkg::*;
#(
    parameter int unsigned DEPTH = ALUS_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_data,
    input  wire logic i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             push;
    logic             pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    // Pointer and count updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow push");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/alus_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alus_back - result sequencer
// Walks the head command: interpolated points first, then the end-of-buffer
// copies, one result per cycle into the output register while it is not stalled.
// ----------------------------------------------------------------------------
module alus_back
    import alus_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_cmd        i_q_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [15:0] o_sample_out,
    output logic             o_final_out
);

    t_phase             r_phase, n_phase;
    logic [1:0]         r_k, n_k;
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_out_sample;
    logic               r_out_final;

    logic       do_interp;
    logic       produce;
    logic       load;
    logic       advance;
    logic [1:0] k_max;
    logic       k_last;
    logic [7:0] pt_a;
    logic [1:0] pt_k;

    // Last point index for this command's factor
    always_comb begin
        case (i_q_cmd.shift)
            2'd0:    k_max = 2'd0;
            2'd1:    k_max = 2'd1;
            default: k_max = 2'd3;
        endcase
    end

    assign k_last    = (r_k == k_max);
    // no held sample: go straight to the copies, if the item has any
    assign do_interp = (r_phase == PH_INTERP) && i_q_cmd.has_prev;
    assign produce   = do_interp || i_q_cmd.last;
    assign load      = i_q_valid && produce && (!r_out_valid || i_out_ready);
    assign advance   = i_q_valid && (!produce || load);

    // Copies are point zero between the new sample and itself
    assign pt_a = do_interp ? i_q_cmd.prev : i_q_cmd.cur;
    assign pt_k = do_interp ? r_k : 2'd0;

    // Sequencer: next phase, index, pop and output valid
    always_comb begin
        n_phase     = r_phase;
        n_k         = r_k;
        o_pop       = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        if (load) begin
            n_out_valid = 1'b1;
        end
        if (advance) begin
            if (!produce) begin
                o_pop   = 1'b1;
                n_phase = PH_INTERP;
                n_k     = '0;
            end else if (k_last) begin
                n_k = '0;
                if (do_interp && i_q_cmd.last) begin
                    n_phase = PH_COPY;
                end else begin
                    o_pop   = 1'b1;
                    n_phase = PH_INTERP;
                end
            end else begin
                n_k = r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INTERP;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_sample <= $signed(interp_point(pt_a, i_q_cmd.cur, pt_k,
                                                 i_q_cmd.shift, i_q_cmd.wide));
            r_out_final  <= !do_interp && k_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_final_out  = r_out_final;

`ifndef ASSERT_OFF
    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_k <= k_max))
        else $error("point index beyond factor");
    a_copy_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COPY) |-> (i_q_valid && i_q_cmd.last))
        else $error("copy phase without end-of-buffer command");
    a_pop_resets_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_phase == PH_INTERP && r_k == 2'd0))
        else $error("sequencer not rewound after pop");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/audio_linear_upsampler.sv =====
`default_nettype none
// An accepted item is first written into the queue; its first result is then
// loaded from the queue head into the output register.
// Throughput: one result per cycle while the output is not stalled: f results per
// item (f = 1, 2, 4), 2f with end of buffer and a held sample, none when it yields
// nothing; the queue takes new items while the back end works, until it is full.
// Reset (synchronous, active low) clears configuration, held sample, queue, output valid.
// ----------------------------------------------------------------------------
// audio_linear_upsampler - linear interpolation upsampler, 1x/2x/4x
// Front end decodes items against the held sample, a short queue decouples
// it from the back end, which emits the results one per cycle when not stalled.
// ----------------------------------------------------------------------------
module audio_linear_upsampler
    import alus_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = ALUS_QUEUE_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire t_cfg_index            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_sample_in,
    input  wire logic                  i_end_of_buffer,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [15:0]         o_sample_out,
    output logic                       o_final_out
);

    logic [1:0] r_rate_code;
    logic       r_wide_output;
    logic       push;
    logic       full;
    logic       q_valid;
    logic       pop;
    t_cmd       push_cmd;
    t_cmd       head_cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_code   <= RATE_1X;
            r_wide_output <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RATE_CODE:   r_rate_code   <= i_cfg_data[1:0];
                CFG_WIDE_OUTPUT: r_wide_output <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    alus_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sample_in     (i_sample_in),
        .i_end_of_buffer (i_end_of_buffer),
        .i_rate_code     (r_rate_code),
        .i_wide_output   (r_wide_output),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    alus_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (head_cmd),
        .i_pop   (pop)
    );

    alus_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (head_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_final_out  (o_final_out)
    );

endmodule
`default_nettype wire
